### hdl/circular_fifo_indexed_read_unit_macros.svh
// assertion macros shared by the checker
`ifndef CIRCULAR_FIFO_INDEXED_READ_UNIT_MACROS_SVH
`define CIRCULAR_FIFO_INDEXED_READ_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cfir_pkg.sv
package cfir_pkg;

  localparam int REQ_W  = 3;
  localparam int DATA_W = 32;
  localparam int OFF_W  = 10;
  localparam int CAP_W  = 11;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH        = 3'd0,
    REQ_POP         = 3'd1,
    REQ_READ_AT     = 3'd2,
    REQ_READ_NEWEST = 3'd3,
    REQ_CLEAR       = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  typedef struct packed {
    logic exec;
    logic resp;
  } ctl_t;

endpackage

### hdl/cfir_ctrl.sv
module cfir_ctrl
  import cfir_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.exec   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        ctl.resp   = 1'b1;
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/cfir_datapath.sv
module cfir_datapath
  import cfir_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int ELEM_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_data,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [DATA_W-1:0] push_data,
  input  logic [OFF_W-1:0]  offset,
  output logic [STAT_W-1:0] status,
  output logic [DATA_W-1:0] read_data,
  output logic [CAP_W-1:0]  occupancy,
  output logic              is_full,
  output logic              is_empty
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = AW + 1;
  localparam int SW      = CW + 1;
  localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [ELEM_BITS-1:0] mem_q;

  logic [AW-1:0]  head, head_next;
  logic [CW-1:0]  fill, fill_next;
  logic [CW-1:0]  cap;
  status_t        stat, stat_next;
  logic           rd_en, rd_en_next;
  logic           wr_en;

  logic [CW-1:0]  addend;
  logic [SW-1:0]  sum, sum_wrap;
  logic [AW-1:0]  addr;
  logic [CW-1:0]  head_inc;
  req_t           req;

  assign req = req_t'(req_type);

  // shared ring adder: one add, one compare and subtract
  always_comb begin
    unique case (req)
      REQ_PUSH:        addend = fill;
      REQ_READ_AT:     addend = CW'(offset);
      REQ_READ_NEWEST: addend = fill - CW'(1);
      default:         addend = '0;
    endcase
    sum      = SW'(head) + SW'(addend);
    sum_wrap = (sum >= SW'(cap)) ? (sum - SW'(cap)) : sum;
    addr     = AW'(sum_wrap);
    head_inc = CW'(head) + CW'(1);
    if (head_inc >= cap) begin
      head_inc = head_inc - cap;
    end
  end

  always_comb begin
    head_next  = head;
    fill_next  = fill;
    stat_next  = ST_OK;
    rd_en_next = 1'b0;
    wr_en      = 1'b0;
    unique case (req)
      REQ_PUSH: begin
        if (fill >= cap) begin
          stat_next = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      REQ_POP: begin
        if (fill == '0) begin
          stat_next = ST_EMPTY;
        end else begin
          rd_en_next = 1'b1;
          fill_next  = fill - CW'(1);
          // emptying pop sends the head back to slot zero
          head_next  = (fill == CW'(1)) ? '0 : AW'(head_inc);
        end
      end
      REQ_READ_AT: begin
        if (32'(offset) >= 32'(fill)) begin
          stat_next = ST_INDEX;
        end else begin
          rd_en_next = 1'b1;
        end
      end
      REQ_READ_NEWEST: begin
        if (fill == '0) begin
          stat_next = ST_EMPTY;
        end else begin
          rd_en_next = 1'b1;
        end
      end
      REQ_CLEAR: begin
        head_next = '0;
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      cap   <= CW'(CAP_RST);
      stat  <= ST_OK;
      rd_en <= 1'b0;
    end else if (cfg_we) begin
      head <= '0;
      fill <= '0;
      if (cfg_data == '0) begin
        cap <= CW'(1);
      end else if (32'(cfg_data) > 32'(DEPTH)) begin
        cap <= CW'(DEPTH);
      end else begin
        cap <= CW'(cfg_data);
      end
    end else if (ctl.exec) begin
      head  <= head_next;
      fill  <= fill_next;
      stat  <= stat_next;
      rd_en <= rd_en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[addr] <= ELEM_BITS'(push_data);
    end
    if (ctl.exec) begin
      mem_q <= mem[addr];
    end
  end

  assign status    = stat;
  assign read_data = rd_en ? DATA_W'(mem_q) : '0;
  assign occupancy = CAP_W'(fill);
  assign is_full   = (fill == cap);
  assign is_empty  = (fill == '0);

endmodule

### hdl/circular_fifo_indexed_read_unit.sv
// a request accepted while idle has its result strobed on done in the next cycle
// the unit takes no new request until the result of the last one has been strobed on done
// busy is high in the result cycle, and start is not taken while busy
// sync reset empties the ring (head and count to zero) and sets capacity to the smaller of DEPTH and 1024
// the element store is not cleared; results cannot be stalled by the receiver
module circular_fifo_indexed_read_unit
  import cfir_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int ELEM_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_data,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [DATA_W-1:0] push_data,
  input  logic [OFF_W-1:0]  offset,
  output logic [STAT_W-1:0] status,
  output logic [DATA_W-1:0] read_data,
  output logic [CAP_W-1:0]  occupancy,
  output logic              is_full,
  output logic              is_empty
);

  ctl_t ctl;

  cfir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctl   (ctl)
  );

  cfir_datapath #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .push_data (push_data),
    .offset    (offset),
    .status    (status),
    .read_data (read_data),
    .occupancy (occupancy),
    .is_full   (is_full),
    .is_empty  (is_empty)
  );

  assign busy = ctl.resp;
  assign done = ctl.resp;

endmodule

### hdl/cfir_checker.sv
`include "circular_fifo_indexed_read_unit_macros.svh"

module cfir_checker
  import cfir_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [STAT_W-1:0] status,
  input logic [DATA_W-1:0] read_data,
  input logic [CAP_W-1:0]  occupancy,
  input logic              is_full,
  input logic              is_empty
);

  // every accepted item gets its result in the next cycle
  `CFIR_ASSERT_NEXT(a_item_done, start && !busy, done, "accepted item produced no result")
  `CFIR_ASSERT_NEXT(a_done_frees, done, !busy, "block stayed busy after a result")
  `CFIR_ASSERT_NOW(a_empty_flag, done, is_empty == (occupancy == '0), "empty flag mismatch")
  `CFIR_ASSERT_NOW(a_flags_excl, done, !(is_full && is_empty), "full and empty together")
  // failed requests never return data
  `CFIR_ASSERT_NOW(a_err_no_data, done && (status != ST_OK), read_data == '0, "data on error")

endmodule

bind circular_fifo_indexed_read_unit cfir_checker u_cfir_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .read_data (read_data),
  .occupancy (occupancy),
  .is_full   (is_full),
  .is_empty  (is_empty)
);
